// ===== rtl/dqu_pkg.sv =====
// ----------------------------------------------------------------------------
// dqu_pkg
// Shared widths, operation codes and status codes of the deque unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dqu_pkg;

   localparam int DQU_DEPTH = 16;
   localparam int WORD_W    = 32;
   localparam int KIND_W    = 2;
   localparam int STAT_W    = 2;

   typedef logic [KIND_W-1:0]        kind_type;
   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [STAT_W-1:0]        stat_type;

   localparam kind_type KIND_PUSH_BACK  = 2'd0;
   localparam kind_type KIND_PUSH_FRONT = 2'd1;
   localparam kind_type KIND_POP_BACK   = 2'd2;
   localparam kind_type KIND_POP_FRONT  = 2'd3;

   localparam stat_type ST_DONE      = 2'd0;
   localparam stat_type ST_UNDERFLOW = 2'd1;
   localparam stat_type ST_FULL      = 2'd2;

   localparam word_type WORD_UNDERFLOW = -32'sd1;

endpackage

`default_nettype wire

// ===== rtl/dqu_req_if.sv =====
// ----------------------------------------------------------------------------
// dqu_req_if
// Request channel: one operation and its word per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqu_req_if
   import dqu_pkg::*;
();
   logic     valid;
   logic     ready;
   kind_type kind;
   word_type value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/dqu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dqu_rsp_if
// Response channel: popped word, status and empty flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqu_rsp_if
   import dqu_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type popped_word;
   stat_type status;
   logic     now_empty;

   modport source (output valid, output popped_word, output status, output now_empty,
                   input ready);
   modport sink   (input valid, input popped_word, input status, input now_empty,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/dqu_ram.sv =====
// ----------------------------------------------------------------------------
// dqu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of signed words in a circular slot RAM.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat contents                         accepted when
//   req_chan  in    kind, value                           valid & ready
//   rsp_chan  out   popped_word, status, now_empty        valid & ready
//
// One request per cycle while ready is high. Pointers and occupancy update
// in the accept cycle, which also issues the slot RAM write (push) or read
// (pop). The RAM read data and the pending op are registered, and the
// result then moves into the output register once that is free.
// Reset clears pointers, occupancy and all valid flags; slot contents are
// left as they are. A stalled response holds the result in the output
// register; the unit keeps one more request in flight behind it and then
// drops ready until the response drains.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit
   import dqu_pkg::*;
#(
   parameter int DEPTH = DQU_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   dqu_req_if.sink   req_chan,
   dqu_rsp_if.source rsp_chan
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

   // pointer state: front indexes the front word, back is one past the back word
   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] back_ff, back_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   // issued op waiting on RAM read data
   logic     pend_valid_ff, pend_valid_in;
   logic     pend_rd_ff, pend_rd_in;
   stat_type pend_stat_ff, pend_stat_in;
   logic     pend_empty_ff, pend_empty_in;

   // output register
   logic     out_valid_ff, out_valid_in;
   word_type out_word_ff, out_word_in;
   stat_type out_stat_ff, out_stat_in;
   logic     out_empty_ff, out_empty_in;

   logic             accept, pend_move;
   logic             is_full, is_empty;
   logic [PTR_W-1:0] front_inc, front_dec, back_inc, back_dec;
   logic             wr_en, rd_en;
   logic [PTR_W-1:0] wr_addr, rd_addr;
   logic [WORD_W-1:0] rd_data;

   assign pend_move = pend_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !pend_valid_ff || pend_move;
   assign accept = req_chan.valid && req_chan.ready;

   assign is_full  = (occ_ff == OCC_FULL);
   assign is_empty = (occ_ff == '0);

   // wrap without relying on a power-of-two depth
   assign front_inc = (front_ff == PTR_LAST) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? PTR_LAST : front_ff - 1'b1;
   assign back_inc  = (back_ff == PTR_LAST) ? '0 : back_ff + 1'b1;
   assign back_dec  = (back_ff == '0) ? PTR_LAST : back_ff - 1'b1;

   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      occ_in       = occ_ff;
      wr_en        = 1'b0;
      wr_addr      = back_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      pend_rd_in   = pend_rd_ff;
      pend_stat_in = pend_stat_ff;
      if (accept) begin
         pend_rd_in   = 1'b0;
         pend_stat_in = ST_DONE;
         unique case (req_chan.kind)
            KIND_PUSH_BACK: begin
               if (is_full) begin
                  pend_stat_in = ST_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = back_ff;
                  back_in = back_inc;
                  occ_in  = occ_ff + 1'b1;
               end
            end
            KIND_PUSH_FRONT: begin
               if (is_full) begin
                  pend_stat_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
                  occ_in   = occ_ff + 1'b1;
               end
            end
            KIND_POP_BACK: begin
               if (is_empty) begin
                  pend_stat_in = ST_UNDERFLOW;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = back_dec;
                  back_in    = back_dec;
                  occ_in     = occ_ff - 1'b1;
                  pend_rd_in = 1'b1;
               end
            end
            KIND_POP_FRONT: begin
               if (is_empty) begin
                  pend_stat_in = ST_UNDERFLOW;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = front_ff;
                  front_in   = front_inc;
                  occ_in     = occ_ff - 1'b1;
                  pend_rd_in = 1'b1;
               end
            end
            default: begin
               pend_stat_in = ST_DONE;
            end
         endcase
      end
   end

   assign pend_empty_in = accept ? (occ_in == '0) : pend_empty_ff;
   assign pend_valid_in = accept || (pend_valid_ff && !pend_move);

   // a push and a pop of the same slot always land in different cycles, and
   // the RAM read data is only overwritten by a new pop, so no forwarding
   dqu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (req_chan.value),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_stat_in  = out_stat_ff;
      out_empty_in = out_empty_ff;
      if (pend_move) begin
         out_valid_in = 1'b1;
         out_stat_in  = pend_stat_ff;
         out_empty_in = pend_empty_ff;
         if (pend_rd_ff) begin
            out_word_in = word_type'(rd_data);
         end else if (pend_stat_ff == ST_UNDERFLOW) begin
            out_word_in = WORD_UNDERFLOW;
         end else begin
            out_word_in = '0;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         back_ff       <= '0;
         occ_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         front_ff      <= front_in;
         back_ff       <= back_in;
         occ_ff        <= occ_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      pend_rd_ff    <= pend_rd_in;
      pend_stat_ff  <= pend_stat_in;
      pend_empty_ff <= pend_empty_in;
      out_word_ff   <= out_word_in;
      out_stat_ff   <= out_stat_in;
      out_empty_ff  <= out_empty_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.popped_word = out_word_ff;
   assign rsp_chan.status      = out_stat_ff;
   assign rsp_chan.now_empty   = out_empty_ff;

endmodule

`default_nettype wire

// ===== rtl/dqu_checker.sv =====
// ----------------------------------------------------------------------------
// dqu_checker
// Port-level checks on the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_checker
   import dqu_pkg::*;
(
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready,
   input wire word_type rsp_popped_word,
   input wire stat_type rsp_status,
   input wire logic     rsp_now_empty
);

   // a stalled response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // underflow returns -1 and leaves the queue empty
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_UNDERFLOW |->
         rsp_popped_word == WORD_UNDERFLOW && rsp_now_empty)
      else $error("underflow beat with wrong word or empty flag");

   // a dropped push means a full queue, which is not empty
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_popped_word == '0 && !rsp_now_empty)
      else $error("full beat with wrong word or empty flag");

   // no response beat right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind double_ended_queue_unit dqu_checker u_dqu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_popped_word (rsp_chan.popped_word),
   .rsp_status      (rsp_chan.status),
   .rsp_now_empty   (rsp_chan.now_empty)
);

`default_nettype wire
